FILE: hw/rtl/icv_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// icv_pkg: shared types and constants of the 3x3 convolution core
// Geometry limits, register indexes, kernel weight table and the structs
// that pass between the control, window and arithmetic stages.
// ----------------------------------------------------------------------------
package icv_pkg;

  localparam int MAX_WIDTH    = 1024;
  localparam int MAX_CHANNELS = 4;
  localparam int SAMPLE_BITS  = 16;

  localparam int LINE_DEPTH = MAX_WIDTH * MAX_CHANNELS;
  localparam int ADDR_W     = $clog2(LINE_DEPTH);
  localparam int WIN_ROW    = 3 * MAX_CHANNELS;
  localparam int WIN_IDX_W  = $clog2(WIN_ROW);

  localparam int CH_W    = 3;
  localparam int W_W     = 11;
  localparam int H_W     = 16;
  localparam int WC_W    = $clog2(LINE_DEPTH + 1);
  localparam int POS_W   = 29;
  localparam int OCOL_W  = $clog2(MAX_WIDTH);
  localparam int OCH_W   = $clog2(MAX_CHANNELS);
  localparam int SUM_W   = 24;
  localparam int RES_W   = 32;
  localparam int SCALE_W = 14;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_KERNEL   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WIDTH    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CHANNELS = 3'd3;

  localparam logic CMD_PUSH  = 1'b0;
  localparam logic CMD_DRAIN = 1'b1;

  localparam logic [2:0] KERNEL_SUM3     = 3'd0;
  localparam logic [2:0] KERNEL_LOWPASS  = 3'd1;
  localparam logic [2:0] KERNEL_GAUSSIAN = 3'd5;

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;

  typedef struct packed {
    sample_t upper;
    sample_t lower;
  } line_word_t;

  typedef struct packed {
    logic              valid;
    sample_t           x;
    logic [ADDR_W-1:0] col;
    logic              emit;
    logic              top;
    logic              bot;
    logic              left;
    logic              right;
    logic              last;
    logic              h1;
  } item_t;

  typedef struct packed {
    logic                   valid;
    logic                   last;
    sample_t [2:0][2:0]     tap;
  } taps_t;

  // Integer weights; the real coefficient is weight times kernel_scale.
  localparam logic signed [3:0] KERNEL_WEIGHT [0:7][0:2][0:2] = '{
    '{'{4'sd0, 4'sd0, 4'sd0}, '{4'sd1, 4'sd1, 4'sd1}, '{4'sd0, 4'sd0, 4'sd0}},
    '{'{4'sd0, 4'sd0, 4'sd0}, '{4'sd1, 4'sd1, 4'sd1}, '{4'sd0, 4'sd0, 4'sd0}},
    '{'{4'sd0, 4'sd0, 4'sd0}, '{4'sd0, -4'sd1, 4'sd1}, '{4'sd0, 4'sd0, 4'sd0}},
    '{'{4'sd0, 4'sd0, 4'sd0}, '{4'sd1, -4'sd2, 4'sd1}, '{4'sd0, 4'sd0, 4'sd0}},
    '{'{4'sd0, -4'sd1, 4'sd0}, '{-4'sd1, 4'sd5, -4'sd1}, '{4'sd0, -4'sd1, 4'sd0}},
    '{'{4'sd1, 4'sd2, 4'sd1}, '{4'sd2, 4'sd4, 4'sd2}, '{4'sd1, 4'sd2, 4'sd1}},
    '{'{4'sd0, 4'sd1, 4'sd0}, '{4'sd1, -4'sd4, 4'sd1}, '{4'sd0, 4'sd1, 4'sd0}},
    '{'{-4'sd2, -4'sd1, 4'sd0}, '{-4'sd1, 4'sd1, 4'sd1}, '{4'sd0, 4'sd1, 4'sd2}}
  };

  function automatic logic [SCALE_W-1:0] kernel_scale(input logic [2:0] k);
    logic [SCALE_W-1:0] s;
    case (k)
      KERNEL_LOWPASS:  s = SCALE_W'(1365);
      KERNEL_GAUSSIAN: s = SCALE_W'(256);
      default:         s = SCALE_W'(4096);
    endcase
    return s;
  endfunction

endpackage

FILE: hw/rtl/icv_stream_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// icv_stream_if: input and result channels of the convolution core
// Valid/ready channels; a word moves when valid and ready are both high.
// ----------------------------------------------------------------------------
interface icv_in_if;
  logic                  valid;
  logic                  ready;
  logic                  command;
  icv_pkg::sample_t      sample;
  modport source (output valid, command, sample, input ready);
  modport sink   (input valid, command, sample, output ready);
endinterface

interface icv_out_if;
  logic                        valid;
  logic                        ready;
  logic signed [icv_pkg::RES_W-1:0] filtered_value;
  logic                        frame_last;
  modport source (output valid, filtered_value, frame_last, input ready);
  modport sink   (input valid, filtered_value, frame_last, output ready);
endinterface

FILE: hw/rtl/image_convolution_3x3_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// image_convolution_3x3_core: streaming 3x3 convolution filter
// Raster-order samples in, Q20.12 filtered words out, channels interleaved.
// ----------------------------------------------------------------------------
// pixel_in carries a command and a sample; a push enters the sample, and a
// drain after all samples of the frame flushes one pending result. A drain
// during the frame is taken and dropped. result_out carries the filtered
// value and frame_last on the final word of the frame.
// Configuration is a write port (cfg_we, cfg_index, cfg_data); a geometry
// write restarts the frame. Write it only while no word is in flight.
// pixel_in is held off during a write and in the cycle after it.
// Throughput is one word per clock when not held off or stalled, as the line
// store is read and written for each word, forwarding when a column repeats.
// A result passes s1, taps, sum3 and the output register once the word that
// releases it is taken; that word is W*C+C stream positions later, or C when H is 1.
// Reset clears all control state and sets the register defaults. The
// line store is not cleared, as stale entries only feed taps outside the frame.
// When result_out stalls, the whole pipeline holds; pixel_in keeps taking
// words as long as the output register is empty or being taken.
// ----------------------------------------------------------------------------
module image_convolution_3x3_core (
  input  logic                           clk,
  input  logic                           rst,
  icv_in_if.sink                         pixel_in,
  icv_out_if.source                      result_out,
  input  logic                           cfg_we,
  input  logic [icv_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [icv_pkg::CFG_DATA_W-1:0] cfg_data
);

  logic                        adv;
  logic                        busy;
  icv_pkg::item_t              s0;
  logic [icv_pkg::CH_W-1:0]    eff_c;
  logic [2:0]                  kernel_select;
  icv_pkg::line_word_t         ram_q, ram_wdata;
  logic                        ram_we;
  logic [icv_pkg::ADDR_W-1:0]  ram_waddr;
  icv_pkg::taps_t              taps;

  assign adv = !result_out.valid || result_out.ready;
  assign pixel_in.ready = adv && !busy;

  icv_ctrl u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_valid      (pixel_in.valid),
    .adv           (adv),
    .command       (pixel_in.command),
    .sample        (pixel_in.sample),
    .s0            (s0),
    .eff_c         (eff_c),
    .kernel_select (kernel_select),
    .busy          (busy)
  );

  icv_line_ram u_ram (
    .clk   (clk),
    .re    (adv),
    .raddr (s0.col),
    .rdata (ram_q),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata)
  );

  icv_window u_window (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .s0        (s0),
    .eff_c     (eff_c),
    .ram_q     (ram_q),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .taps      (taps)
  );

  icv_mac u_mac (
    .clk           (clk),
    .rst           (rst),
    .adv           (adv),
    .kernel_select (kernel_select),
    .taps          (taps),
    .out_valid     (result_out.valid),
    .out_value     (result_out.filtered_value),
    .out_last      (result_out.frame_last)
  );

endmodule

FILE: hw/rtl/icv_line_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// icv_line_ram: line store memory
// Holds both delayed rows per column; one write and one registered read.
// ----------------------------------------------------------------------------
module icv_line_ram (
  input  logic                       clk,
  input  logic                       re,
  input  logic [icv_pkg::ADDR_W-1:0] raddr,
  output icv_pkg::line_word_t        rdata,
  input  logic                       we,
  input  logic [icv_pkg::ADDR_W-1:0] waddr,
  input  icv_pkg::line_word_t        wdata
);

  icv_pkg::line_word_t mem [icv_pkg::LINE_DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: hw/rtl/icv_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// icv_ctrl: configuration registers and stream position tracking
// Decides per word whether it enters, where it goes in the line store and
// which frame borders the result it releases touches.
// ----------------------------------------------------------------------------
module icv_ctrl (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [icv_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [icv_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                           in_valid,
  input  logic                           adv,
  input  logic                           command,
  input  icv_pkg::sample_t               sample,
  output icv_pkg::item_t                 s0,
  output logic [icv_pkg::CH_W-1:0]       eff_c,
  output logic [2:0]                     kernel_select,
  output logic                           busy
);

  logic [icv_pkg::W_W-1:0]    frame_width;
  logic [icv_pkg::H_W-1:0]    frame_height;
  logic [icv_pkg::CH_W-1:0]   channel_count;

  logic [icv_pkg::W_W-1:0]    eff_w;
  logic [icv_pkg::H_W-1:0]    eff_h;
  logic [icv_pkg::POS_W-1:0]  total;
  logic [icv_pkg::POS_W-1:0]  lat;
  logic [icv_pkg::WC_W-1:0]   wc;

  logic [icv_pkg::W_W-1:0]    w_c;
  logic [icv_pkg::H_W-1:0]    h_c;
  logic [icv_pkg::CH_W-1:0]   c_c;
  logic [icv_pkg::WC_W-1:0]   wc_c;

  logic [icv_pkg::POS_W-1:0]  pos;
  logic [icv_pkg::ADDR_W-1:0] col;
  logic [icv_pkg::OCH_W-1:0]  oc_ch;
  logic [icv_pkg::OCOL_W-1:0] oc_c;
  logic [icv_pkg::H_W-1:0]    oc_r;
  logic                       settle;

  logic full, ignore, take, emit, last, end_ch, end_col;

  always_comb begin
    if (frame_width == '0) begin
      w_c = icv_pkg::W_W'(1);
    end else if (frame_width > icv_pkg::W_W'(icv_pkg::MAX_WIDTH)) begin
      w_c = icv_pkg::W_W'(icv_pkg::MAX_WIDTH);
    end else begin
      w_c = frame_width;
    end
    h_c = (frame_height == '0) ? icv_pkg::H_W'(1) : frame_height;
    if (channel_count == '0) begin
      c_c = icv_pkg::CH_W'(1);
    end else if (channel_count > icv_pkg::CH_W'(icv_pkg::MAX_CHANNELS)) begin
      c_c = icv_pkg::CH_W'(icv_pkg::MAX_CHANNELS);
    end else begin
      c_c = channel_count;
    end
    wc_c = icv_pkg::WC_W'(icv_pkg::WC_W'(w_c) * icv_pkg::WC_W'(c_c));
  end

  // Geometry is registered once so the stream path sees only flops.
  always_ff @(posedge clk) begin
    eff_w <= w_c;
    eff_h <= h_c;
    eff_c <= c_c;
    wc    <= wc_c;
    total <= icv_pkg::POS_W'(icv_pkg::POS_W'(wc_c) * icv_pkg::POS_W'(h_c));
    lat   <= (h_c > icv_pkg::H_W'(1))
             ? icv_pkg::POS_W'(wc_c) + icv_pkg::POS_W'(c_c)
             : icv_pkg::POS_W'(c_c);
  end

  // The registered geometry takes another register stage after a register write, so input
  // is held off during the write and the cycle after it.
  always_ff @(posedge clk) begin
    if (rst) begin
      settle <= 1'b1;
    end else begin
      settle <= cfg_we;
    end
  end

  always_comb begin
    busy    = settle || cfg_we;
    full    = pos >= total;
    ignore  = !full && (command == icv_pkg::CMD_DRAIN);
    take    = in_valid && adv && !busy && !ignore;
    emit    = pos >= lat;
    end_ch  = {1'b0, oc_ch} == icv_pkg::CH_W'(eff_c - 1'b1);
    end_col = {1'b0, oc_c} == icv_pkg::W_W'(eff_w - 1'b1);
    last    = emit && end_ch && end_col && (oc_r == icv_pkg::H_W'(eff_h - 1'b1));

    s0.valid = take;
    s0.x     = full ? '0 : sample;
    s0.col   = col;
    s0.emit  = emit;
    s0.top   = oc_r == '0;
    s0.bot   = oc_r == icv_pkg::H_W'(eff_h - 1'b1);
    s0.left  = oc_c == '0;
    s0.right = end_col;
    s0.last  = last;
    s0.h1    = eff_h == icv_pkg::H_W'(1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      kernel_select <= '0;
      frame_width   <= icv_pkg::W_W'(1024);
      frame_height  <= icv_pkg::H_W'(1);
      channel_count <= icv_pkg::CH_W'(3);
      pos   <= '0;
      col   <= '0;
      oc_ch <= '0;
      oc_c  <= '0;
      oc_r  <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        icv_pkg::REG_KERNEL:   kernel_select <= cfg_data[2:0];
        icv_pkg::REG_WIDTH:    frame_width   <= cfg_data[icv_pkg::W_W-1:0];
        icv_pkg::REG_HEIGHT:   frame_height  <= cfg_data[icv_pkg::H_W-1:0];
        icv_pkg::REG_CHANNELS: channel_count <= cfg_data[icv_pkg::CH_W-1:0];
        default: ;
      endcase
      // A geometry change starts a new frame.
      if (cfg_index inside {icv_pkg::REG_WIDTH, icv_pkg::REG_HEIGHT,
                            icv_pkg::REG_CHANNELS}) begin
        pos   <= '0;
        col   <= '0;
        oc_ch <= '0;
        oc_c  <= '0;
        oc_r  <= '0;
      end
    end else if (take) begin
      if (last) begin
        pos   <= '0;
        col   <= '0;
        oc_ch <= '0;
        oc_c  <= '0;
        oc_r  <= '0;
      end else begin
        pos <= pos + 1'b1;
        if (icv_pkg::WC_W'(col) + 1'b1 == wc) begin
          col <= '0;
        end else begin
          col <= col + 1'b1;
        end
        if (emit) begin
          if (end_ch) begin
            oc_ch <= '0;
            if (end_col) begin
              oc_c <= '0;
              oc_r <= oc_r + 1'b1;
            end else begin
              oc_c <= oc_c + 1'b1;
            end
          end else begin
            oc_ch <= oc_ch + 1'b1;
          end
        end
      end
    end
  end

endmodule

FILE: hw/rtl/icv_window.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// icv_window: line store update and 3x3 window
// Rotates the line store words, shifts the window and picks the nine taps
// of the centered pixel, zeroing those that fall outside the frame.
// ----------------------------------------------------------------------------
module icv_window (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       adv,
  input  icv_pkg::item_t             s0,
  input  logic [icv_pkg::CH_W-1:0]   eff_c,
  input  icv_pkg::line_word_t        ram_q,
  output logic                       ram_we,
  output logic [icv_pkg::ADDR_W-1:0] ram_waddr,
  output icv_pkg::line_word_t        ram_wdata,
  output icv_pkg::taps_t             taps
);

  icv_pkg::item_t      s1;
  logic                fwd;
  icv_pkg::line_word_t fwd_word;
  icv_pkg::sample_t    win [3][icv_pkg::WIN_ROW];

  icv_pkg::line_word_t rd;
  icv_pkg::sample_t    newest [3];
  icv_pkg::sample_t    t_near [3];
  icv_pkg::sample_t    t_mid [3];
  icv_pkg::sample_t    t_far [3];
  icv_pkg::sample_t [2:0][2:0] tap_next;
  logic [icv_pkg::WIN_IDX_W-1:0] idx1, idx2;
  logic [2:0] row_ok;
  int r;

  always_comb begin
    // The previous word wrote this column in the cycle it was read.
    rd = fwd ? fwd_word : ram_q;
    ram_we          = adv && s1.valid;
    ram_waddr       = s1.col;
    ram_wdata.upper = rd.lower;
    ram_wdata.lower = s1.x;

    newest[0] = rd.upper;
    newest[1] = rd.lower;
    newest[2] = s1.x;

    idx1 = icv_pkg::WIN_IDX_W'(eff_c - 1'b1);
    idx2 = icv_pkg::WIN_IDX_W'({eff_c, 1'b0} - 1'b1);
    for (r = 0; r < 3; r++) begin
      t_near[r] = newest[r];
      t_mid[r]  = win[r][idx1];
      t_far[r]  = win[r][idx2];
    end

    row_ok[0] = !s1.h1 && !s1.top;
    row_ok[1] = 1'b1;
    row_ok[2] = !s1.h1 && !s1.bot;

    for (r = 0; r < 3; r++) begin
      // A single-row frame takes its middle row from the newest samples.
      if (r == 1 && s1.h1) begin
        tap_next[r][0] = s1.left  ? '0 : t_far[2];
        tap_next[r][1] = t_mid[2];
        tap_next[r][2] = s1.right ? '0 : t_near[2];
      end else begin
        tap_next[r][0] = (!row_ok[r] || s1.left)  ? '0 : t_far[r];
        tap_next[r][1] = !row_ok[r] ? '0 : t_mid[r];
        tap_next[r][2] = (!row_ok[r] || s1.right) ? '0 : t_near[r];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1.valid   <= 1'b0;
      taps.valid <= 1'b0;
      fwd        <= 1'b0;
    end else if (adv) begin
      s1.valid   <= s0.valid;
      taps.valid <= s1.valid && s1.emit;
      fwd        <= s0.valid && s1.valid && (s0.col == s1.col);
    end
    if (adv) begin
      s1.x     <= s0.x;
      s1.col   <= s0.col;
      s1.emit  <= s0.emit;
      s1.top   <= s0.top;
      s1.bot   <= s0.bot;
      s1.left  <= s0.left;
      s1.right <= s0.right;
      s1.last  <= s0.last;
      s1.h1    <= s0.h1;
      fwd_word <= ram_wdata;
      taps.last <= s1.last;
      taps.tap  <= tap_next;
    end
    if (adv && s1.valid) begin
      for (int k = 0; k < 3; k++) begin
        for (int j = icv_pkg::WIN_ROW - 1; j > 0; j--) begin
          win[k][j] <= win[k][j-1];
        end
        win[k][0] <= newest[k];
      end
    end
  end

endmodule

FILE: hw/rtl/icv_mac.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// icv_mac: kernel arithmetic and output register
// Weighted sum of the nine taps with small integer weights, then one
// scale multiply to Q20.12 into the output register.
// ----------------------------------------------------------------------------
module icv_mac (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            adv,
  input  logic [2:0]                      kernel_select,
  input  icv_pkg::taps_t                  taps,
  output logic                            out_valid,
  output logic signed [icv_pkg::RES_W-1:0] out_value,
  output logic                            out_last
);

  logic                             v3;
  logic                             last3;
  logic signed [icv_pkg::SUM_W-1:0] sum3;
  logic signed [icv_pkg::SUM_W-1:0] acc;

  always_comb begin
    acc = '0;
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        acc = acc + icv_pkg::SUM_W'(taps.tap[i][j])
                  * icv_pkg::SUM_W'(icv_pkg::KERNEL_WEIGHT[kernel_select][i][j]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v3        <= 1'b0;
      out_valid <= 1'b0;
    end else if (adv) begin
      v3        <= taps.valid;
      out_valid <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sum3      <= acc;
      last3     <= taps.last;
      out_last  <= last3;
      out_value <= icv_pkg::RES_W'(icv_pkg::RES_W'(sum3)
                   * icv_pkg::RES_W'(icv_pkg::kernel_scale(kernel_select)));
    end
  end

endmodule

FILE: verif/image_convolution_3x3_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// image_convolution_3x3_core_tb: self-checking bench of the 3x3 convolution
// Frames of random geometry and kernel are streamed through the core with
// bursty input and a stalling receiver. Each result is checked against a
// behavioral filter that keeps its own line stores, window and positions.
// ----------------------------------------------------------------------------
module image_convolution_3x3_core_tb;
  import icv_pkg::*;

  localparam int TIMEOUT_CYCLES = 600000;

  typedef struct {
    logic        cmd;
    sample_t     smp;
  } word_t;

  typedef struct {
    logic signed [31:0] value;
    logic               last;
  } filt_result_t;

  // Q4.12 weights, rows top to bottom, taps left to right.
  localparam int COEF [8][3][3] = '{
    '{'{0, 0, 0}, '{4096, 4096, 4096}, '{0, 0, 0}},
    '{'{0, 0, 0}, '{1365, 1365, 1365}, '{0, 0, 0}},
    '{'{0, 0, 0}, '{0, -4096, 4096}, '{0, 0, 0}},
    '{'{0, 0, 0}, '{4096, -8192, 4096}, '{0, 0, 0}},
    '{'{0, -4096, 0}, '{-4096, 20480, -4096}, '{0, -4096, 0}},
    '{'{256, 512, 256}, '{512, 1024, 512}, '{256, 512, 256}},
    '{'{0, 4096, 0}, '{4096, -16384, 4096}, '{0, 4096, 0}},
    '{'{-8192, -4096, 0}, '{-4096, 4096, 4096}, '{0, 4096, 8192}}
  };

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  icv_in_if  pixel_in ();
  icv_out_if result_out ();

  image_convolution_3x3_core dut (
    .clk(clk), .rst(rst), .pixel_in(pixel_in), .result_out(result_out),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #2 clk = ~clk;

  // Filter state mirrored by the bench.
  int kern_sel, geo_w, geo_h, geo_c;
  int upper_line [LINE_DEPTH];
  int lower_line [LINE_DEPTH];
  int win [3][WIN_ROW];
  int stream_pos;

  word_t        pending_words [$];
  filt_result_t expected_results [$];
  int errors = 0;
  int results_seen = 0;
  int frames_run = 0;
  int cycle_count = 0;
  int words_queued = 0;

  function automatic int eff_w();
    return (geo_w == 0) ? 1 : (geo_w > MAX_WIDTH ? MAX_WIDTH : geo_w);
  endfunction
  function automatic int eff_h();
    return (geo_h == 0) ? 1 : geo_h;
  endfunction
  function automatic int eff_c();
    return (geo_c == 0) ? 1 : (geo_c > MAX_CHANNELS ? MAX_CHANNELS : geo_c);
  endfunction
  function automatic int release_lag();
    return (eff_h() > 1) ? eff_w() * eff_c() + eff_c() : eff_c();
  endfunction

  function automatic void filter_reset();
    kern_sel = 0; geo_w = 1024; geo_h = 1; geo_c = 3; stream_pos = 0;
    for (int i = 0; i < LINE_DEPTH; i++) begin
      upper_line[i] = 0;
      lower_line[i] = 0;
    end
    for (int r = 0; r < 3; r++)
      for (int j = 0; j < WIN_ROW; j++) win[r][j] = 0;
  endfunction

  function automatic void filter_config(logic [CFG_IDX_W-1:0] idx, int val);
    case (idx)
      REG_KERNEL:   kern_sel = val & 7;
      REG_WIDTH:    geo_w = val & 'h7FF;
      REG_HEIGHT:   geo_h = val & 'hFFFF;
      REG_CHANNELS: geo_c = val & 7;
      default: ;
    endcase
    if (idx == REG_WIDTH || idx == REG_HEIGHT || idx == REG_CHANNELS) stream_pos = 0;
  endfunction

  function automatic void filter_word(logic cmd, sample_t smp);
    int w, h, ch, wc, total, lag, p, x, col, q, r, c, slot, tap;
    longint acc;
    filt_result_t res;
    w = eff_w(); h = eff_h(); ch = eff_c();
    wc = w * ch; total = wc * h; lag = release_lag();
    p = stream_pos;
    if (p < total) begin
      if (cmd == CMD_DRAIN) return;
      x = smp;
    end else begin
      x = 0;
    end
    for (int j = WIN_ROW - 1; j > 0; j--)
      for (int k = 0; k < 3; k++) win[k][j] = win[k][j-1];
    col = (p % wc) % LINE_DEPTH;
    win[0][0] = upper_line[col];
    win[1][0] = lower_line[col];
    win[2][0] = x;
    upper_line[col] = lower_line[col];
    lower_line[col] = x;
    stream_pos = p + 1;
    if (p < lag) return;
    q = p - lag;
    r = q / wc;
    c = (q % wc) / ch;
    acc = 0;
    for (int dr = -1; dr <= 1; dr++) begin
      if (r + dr < 0 || r + dr >= h) continue;
      for (int dc = -1; dc <= 1; dc++) begin
        if (c + dc < 0 || c + dc >= w) continue;
        slot = (h == 1) ? 2 : dr + 1;
        tap = (1 - dc) * ch;
        acc += longint'(win[slot][tap]) * longint'(COEF[kern_sel][dr+1][dc+1]);
      end
    end
    res.value = acc[31:0];
    res.last = (q == total - 1);
    expected_results = {expected_results, res};
    if (q == total - 1) stream_pos = 0;
  endfunction

  // Input driver: bursts of random length separated by random gaps.
  int burst_left = 0;
  int gap_left = 0;
  always @(posedge clk) begin
    if (rst) begin
      pixel_in.valid <= 1'b0;
      pixel_in.command <= CMD_PUSH;
      pixel_in.sample <= '0;
    end else if (!(pixel_in.valid && !pixel_in.ready)) begin
      if (gap_left > 0) begin
        gap_left--;
        pixel_in.valid <= 1'b0;
      end else if (pending_words.size() > 0) begin
        word_t wd;
        wd = pending_words.pop_front();
        pixel_in.valid <= 1'b1;
        pixel_in.command <= wd.cmd;
        pixel_in.sample <= wd.smp;
        if (burst_left > 0) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(1, 40);
          gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 5);
        end
      end else begin
        pixel_in.valid <= 1'b0;
      end
    end
  end

  // Receiver stall pattern: modes change now and then.
  int stall_mode = 0;
  int stall_span = 0;
  always @(posedge clk) begin
    if (rst) begin
      result_out.ready <= 1'b0;
    end else begin
      if (stall_span == 0) begin
        stall_mode = $urandom_range(0, 3);
        stall_span = $urandom_range(10, 80);
      end else begin
        stall_span--;
      end
      case (stall_mode)
        0: result_out.ready <= 1'b1;
        1: result_out.ready <= ($urandom_range(0, 3) != 0);
        2: result_out.ready <= ($urandom_range(0, 1) != 0);
        default: result_out.ready <= ((cycle_count % 7) > 3);
      endcase
    end
  end

  // Prediction on accepted input words, checking on accepted results.
  always @(posedge clk) begin
    if (!rst) begin
      if (pixel_in.valid && pixel_in.ready)
        filter_word(pixel_in.command, pixel_in.sample);
      if (result_out.valid && result_out.ready) begin
        results_seen++;
        if (expected_results.size() == 0) begin
          $error("unexpected result word: filtered_value %0d frame_last %0b",
                 result_out.filtered_value, result_out.frame_last);
          errors++;
        end else begin
          filt_result_t exp_res;
          exp_res = expected_results.pop_front();
          if (result_out.filtered_value !== exp_res.value) begin
            $error("filtered_value: expected %0d, actual %0d",
                   exp_res.value, result_out.filtered_value);
            errors++;
          end
          if (result_out.frame_last !== exp_res.last) begin
            $error("frame_last: expected %0b, actual %0b",
                   exp_res.last, result_out.frame_last);
            errors++;
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > TIMEOUT_CYCLES) begin
      $display("timeout with %0d results outstanding", expected_results.size());
      $display("*** FAILED ***");
      $finish;
    end
  end

  task automatic wait_idle();
    while (pending_words.size() > 0 || pixel_in.valid || expected_results.size() > 0)
      @(posedge clk);
    // Words that cause no result may still be in the pipeline.
    repeat (12) @(posedge clk);
  endtask

  task automatic write_regs(int k, int w, int h, int c);
    int vals [4];
    vals = '{k, w, h, c};
    for (int i = 0; i < 4; i++) begin
      @(posedge clk);
      cfg_we <= 1'b1;
      cfg_index <= i[CFG_IDX_W-1:0];
      cfg_data <= vals[i][CFG_DATA_W-1:0];
      filter_config(i[CFG_IDX_W-1:0], vals[i]);
    end
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic sample_t rand_sample();
    case ($urandom_range(0, 11))
      0: return 16'sh8000;
      1: return 16'sh7FFF;
      2: return 16'sh0000;
      3: return 16'shFFFF;
      default: return sample_t'($urandom);
    endcase
  endfunction

  function automatic void queue_word(logic cmd, sample_t smp);
    word_t wd;
    wd.cmd = cmd;
    wd.smp = smp;
    pending_words = {pending_words, wd};
    words_queued++;
  endfunction

  // One full frame plus the drains that flush it; noise adds ignored drains
  // inside the frame and pushes among the flushing drains.
  task automatic queue_frame(bit noisy, output int pushes);
    int total, lag;
    total = eff_w() * eff_h() * eff_c();
    lag = release_lag();
    pushes = total;
    for (int i = 0; i < total; i++) begin
      if (noisy && $urandom_range(0, 11) == 0) queue_word(CMD_DRAIN, rand_sample());
      queue_word(CMD_PUSH, rand_sample());
    end
    for (int i = 0; i < lag; i++)
      queue_word((noisy && $urandom_range(0, 4) == 0) ? CMD_PUSH : CMD_DRAIN,
                 rand_sample());
    frames_run++;
  endtask

  initial begin
    int pushed, n, w, h, c, phase;
    pixel_in.valid = 1'b0;
    pixel_in.command = CMD_PUSH;
    pixel_in.sample = '0;
    result_out.ready = 1'b0;
    filter_reset();
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Directed: sharpen over a 3x3 frame of extreme values with a drain
    // inside the frame, then a fully degenerate geometry.
    write_regs(4, 3, 3, 1);
    queue_word(CMD_PUSH, 16'sh7FFF);
    queue_word(CMD_PUSH, 16'sh8000);
    queue_word(CMD_DRAIN, 16'sh1234);
    queue_word(CMD_PUSH, 16'sh7FFF);
    queue_word(CMD_PUSH, 16'sh8000);
    queue_word(CMD_PUSH, 16'sh7FFF);
    queue_word(CMD_PUSH, 16'sh8000);
    queue_word(CMD_PUSH, 16'sh7FFF);
    queue_word(CMD_PUSH, 16'sh8000);
    queue_word(CMD_PUSH, 16'sh7FFF);
    for (int i = 0; i < 4; i++) queue_word(CMD_DRAIN, 16'sh0000);
    wait_idle();
    write_regs(7, 0, 0, 0);
    queue_frame(1'b0, n);
    wait_idle();

    // Tall frame that is abandoned after a few rows; the rewrite restarts it.
    write_regs(5, 1, 65535, 1);
    for (int i = 0; i < 6; i++) queue_word(CMD_PUSH, rand_sample());
    wait_idle();

    // Clamped width and channels on a row that is left unfinished, then a
    // short two-row frame.
    write_regs(6, 2047, 1, 7);
    for (int i = 0; i < 40; i++) queue_word(CMD_PUSH, rand_sample());
    wait_idle();
    write_regs(3, 9, 2, 1);
    queue_frame(1'b1, n);
    wait_idle();

    pushed = 0;
    phase = 0;
    while (words_queued < 950) begin
      w = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 8);
      h = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 4);
      c = $urandom_range(0, 7);
      write_regs(phase % 8, w, h, c);
      for (int f = $urandom_range(1, 2); f > 0; f--) begin
        queue_frame($urandom_range(0, 2) != 0, n);
        pushed += n;
      end
      wait_idle();
      phase++;
    end

    wait_idle();
    $display("Ran %0d frames over all eight kernels and clamped geometries;",
             frames_run);
    $display("%0d words sent (%0d random-frame samples), %0d result words checked.",
             words_queued, pushed, results_seen);
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
